// ----- rtl/swfd_pkg.sv -----
// Shared types and constants of the sync word frame deframer.
// Used by the controller, the datapath, the top level and the checker.
package swfd_pkg;

	localparam int MAX_FRAME = 64;
	localparam int ADDR_W    = $clog2(MAX_FRAME);
	localparam int FILL_W    = $clog2(MAX_FRAME + 1);
	localparam int HDR_BYTES = 6;

	localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND   = 8'h55;
	localparam logic [15:0] MIN_PAYLOAD   = 16'd3;
	localparam logic [15:0] MAX_PAYLOAD   = 16'(MAX_FRAME - HDR_BYTES);
	localparam logic [15:0] SPECIAL_REPLY = 16'h100F;
	localparam logic [7:0]  MARK_STATUS   = 8'hFE;
	localparam logic [7:0]  MARK_FAILED   = 8'hFF;
	localparam logic [7:0]  RES_SUCCESS   = 8'd4;
	localparam logic [7:0]  RES_FAILED    = 8'd5;

	// configuration register indexes
	localparam logic [2:0] REG_IMU_TYPE    = 3'd0;
	localparam logic [2:0] REG_IMU_LEN     = 3'd1;
	localparam logic [2:0] REG_VSYNC_TYPE  = 3'd2;
	localparam logic [2:0] REG_VSYNC_LEN   = 3'd3;
	localparam logic [2:0] REG_HANDLE_TYPE = 3'd4;
	localparam logic [2:0] REG_HANDLE_LEN  = 3'd5;

	// frame kinds
	localparam logic [1:0] KIND_IMU    = 2'd0;
	localparam logic [1:0] KIND_VSYNC  = 2'd1;
	localparam logic [1:0] KIND_HANDLE = 2'd2;
	localparam logic [1:0] KIND_REPLY  = 2'd3;

	// reply status codes
	localparam logic [1:0] RS_PENDING = 2'd0;
	localparam logic [1:0] RS_SUCCESS = 2'd1;
	localparam logic [1:0] RS_FAILED  = 2'd2;
	localparam logic [1:0] RS_UNKNOWN = 2'd3;

	// m_tdata bit positions
	localparam int OUT_CK_BIT  = 24;
	localparam int OUT_FWD_BIT = 25;
	localparam int OUT_OVS_BIT = 28;

	typedef struct packed {
		logic store;
		logic arm;
		logic drop;
		logic clear;
		logic load_ovs;
		logic load_bad;
		logic start_emit;
		logic settle;
		logic load_byte;
		logic advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hdr_full;
		logic hdr_ok;
		logic oversize;
		logic frame_done;
		logic is_data;
		logic ck_ok;
		logic out_taken;
		logic out_last;
	} dp_status_t;

endpackage

// ----- rtl/swfd_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/swfd_dp.sv -----
// Datapath: header registers, frame store RAM, checksum, reply tracking, output register.
// Depends on swfd_pkg and swfd_ram.
module swfd_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swfd_pkg::ctrl_cmd_t     cmd,
	output swfd_pkg::dp_status_t    status,
	input  logic [7:0]              rx_byte,
	input  logic [15:0]             awaited_code,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data,
	input  logic                    m_tready,
	output logic                    m_tvalid,
	output logic [31:0]             m_tdata,
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);

	logic [15:0] imu_type_q, vsync_type_q, handle_type_q;
	logic [5:0]  imu_len_q, vsync_len_q, handle_len_q;

	logic [7:0]  hdr_q [swfd_pkg::HDR_BYTES];
	logic [swfd_pkg::FILL_W-1:0] fill_q;
	logic [7:0]  xor_q;
	logic [15:0] pending_q;
	logic [1:0]  reply_q;
	logic [15:0] type_q;
	logic [7:0]  mark_q, res_q;

	logic [swfd_pkg::ADDR_W-1:0] idx_q, end_q;
	logic [1:0] kind_q;
	logic       ck_q;

	logic        out_valid_q, out_last_q, out_ck_q, out_fwd_q, out_ovs_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  out_kind_q, out_status_q;
	logic [15:0] out_type_q;

	logic [swfd_pkg::FILL_W-1:0] pos;
	logic [15:0] total, plen;
	logic [1:0]  kind;
	logic        ram_we;
	logic [7:0]  ram_rdata;
	logic [7:0]  load_val;
	logic [7:0]  res_eff;
	logic [1:0]  settle_val;

	assign pos    = (fill_q == swfd_pkg::FILL_W'(swfd_pkg::MAX_FRAME)) ? '0 : fill_q;
	assign total  = {hdr_q[1], hdr_q[0]};
	assign plen   = {hdr_q[5], hdr_q[4]};
	assign ram_we = cmd.store && (pos >= swfd_pkg::FILL_W'(swfd_pkg::HDR_BYTES));

	always_comb begin
		priority if (type_q == imu_type_q && plen == {10'd0, imu_len_q}) begin
			kind = swfd_pkg::KIND_IMU;
		end else if (type_q == vsync_type_q && plen == {10'd0, vsync_len_q}) begin
			kind = swfd_pkg::KIND_VSYNC;
		end else if (type_q == handle_type_q && plen == {10'd0, handle_len_q}) begin
			kind = swfd_pkg::KIND_HANDLE;
		end else begin
			kind = swfd_pkg::KIND_REPLY;
		end
	end

	always_comb begin
		status.hdr_full   = (fill_q == swfd_pkg::FILL_W'(swfd_pkg::HDR_BYTES));
		status.hdr_ok     = hdr_q[2] == swfd_pkg::SYNC_FIRST && hdr_q[3] == swfd_pkg::SYNC_SECOND
		                 && {1'b0, total} == ({1'b0, plen} + 17'd4)
		                 && plen >= swfd_pkg::MIN_PAYLOAD;
		status.oversize   = plen > swfd_pkg::MAX_PAYLOAD;
		// plen is known to fit the store once the header has passed
		status.frame_done = fill_q > swfd_pkg::FILL_W'(swfd_pkg::HDR_BYTES)
		                 && fill_q == (swfd_pkg::FILL_W'(plen[swfd_pkg::ADDR_W-1:0])
		                               + swfd_pkg::FILL_W'(swfd_pkg::HDR_BYTES));
		status.is_data    = kind != swfd_pkg::KIND_REPLY;
		status.ck_ok      = xor_q == 8'd0;
		status.out_taken  = out_valid_q && m_tready;
		status.out_last   = out_last_q;
	end

	// reply status once settled; byte 15 lies beyond a short frame
	always_comb begin
		res_eff = (plen > 16'd9) ? res_q : 8'd0;
		if (type_q == swfd_pkg::SPECIAL_REPLY) begin
			priority if (mark_q == swfd_pkg::MARK_STATUS) begin
				priority if (res_eff == swfd_pkg::RES_SUCCESS) settle_val = swfd_pkg::RS_SUCCESS;
				else if (res_eff == swfd_pkg::RES_FAILED) settle_val = swfd_pkg::RS_FAILED;
				else settle_val = swfd_pkg::RS_UNKNOWN;
			end else if (mark_q == swfd_pkg::MARK_FAILED) begin
				settle_val = swfd_pkg::RS_FAILED;
			end else begin
				settle_val = swfd_pkg::RS_SUCCESS;
			end
		end else begin
			settle_val = swfd_pkg::RS_SUCCESS;
		end
	end

	swfd_ram #(.WIDTH(8), .DEPTH(swfd_pkg::MAX_FRAME)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos[swfd_pkg::ADDR_W-1:0]),
		.wdata (rx_byte),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign load_val = (idx_q < swfd_pkg::ADDR_W'(swfd_pkg::HDR_BYTES)) ? hdr_q[idx_q[2:0]]
	                                                                 : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imu_type_q    <= 16'd618;
			imu_len_q     <= 6'd26;
			vsync_type_q  <= 16'd3841;
			vsync_len_q   <= 6'd16;
			handle_type_q <= 16'd620;
			handle_len_q  <= 6'd17;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swfd_pkg::REG_IMU_TYPE:    imu_type_q    <= cfg_data;
				swfd_pkg::REG_IMU_LEN:     imu_len_q     <= cfg_data[5:0];
				swfd_pkg::REG_VSYNC_TYPE:  vsync_type_q  <= cfg_data;
				swfd_pkg::REG_VSYNC_LEN:   vsync_len_q   <= cfg_data[5:0];
				swfd_pkg::REG_HANDLE_TYPE: handle_type_q <= cfg_data;
				swfd_pkg::REG_HANDLE_LEN:  handle_len_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			xor_q       <= '0;
			pending_q   <= '0;
			reply_q     <= swfd_pkg::RS_PENDING;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.arm) begin
				pending_q <= awaited_code;
				reply_q   <= swfd_pkg::RS_PENDING;
			end
			if (cmd.store) begin
				fill_q <= pos + 1'b1;
				xor_q  <= ((fill_q == swfd_pkg::FILL_W'(swfd_pkg::MAX_FRAME)) ? 8'd0 : xor_q)
				          ^ rx_byte;
			end
			if (cmd.drop) begin
				fill_q <= swfd_pkg::FILL_W'(swfd_pkg::HDR_BYTES - 1);
				xor_q  <= xor_q ^ hdr_q[0];
			end
			if (cmd.clear) begin
				fill_q <= '0;
				xor_q  <= '0;
			end
			if (cmd.settle && reply_q == swfd_pkg::RS_PENDING && type_q == pending_q) begin
				reply_q <= settle_val;
			end
			if (cmd.load_ovs || cmd.load_bad || cmd.load_byte) begin
				out_valid_q <= 1'b1;
			end else if (status.out_taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (pos < swfd_pkg::FILL_W'(swfd_pkg::HDR_BYTES)) begin
				hdr_q[pos[2:0]] <= rx_byte;
			end
			unique case (pos)
				swfd_pkg::FILL_W'(6):  type_q[7:0]  <= rx_byte;
				swfd_pkg::FILL_W'(7):  type_q[15:8] <= rx_byte;
				swfd_pkg::FILL_W'(8):  mark_q       <= rx_byte;
				swfd_pkg::FILL_W'(15): res_q        <= rx_byte;
				default: ;
			endcase
		end
		if (cmd.drop) begin
			for (int i = 0; i < swfd_pkg::HDR_BYTES - 1; i++) begin
				hdr_q[i] <= hdr_q[i+1];
			end
		end
		if (cmd.start_emit) begin
			kind_q <= kind;
			ck_q   <= status.ck_ok;
			idx_q  <= status.is_data ? '0 : swfd_pkg::ADDR_W'(4);
			end_q  <= plen[swfd_pkg::ADDR_W-1:0] + swfd_pkg::ADDR_W'(5);
		end else if (cmd.advance) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.load_ovs) begin
			out_byte_q   <= '0;
			out_kind_q   <= '0;
			out_type_q   <= '0;
			out_ck_q     <= 1'b0;
			out_fwd_q    <= 1'b0;
			out_ovs_q    <= 1'b1;
			out_status_q <= reply_q;
			out_last_q   <= 1'b1;
		end else if (cmd.load_bad) begin
			out_byte_q   <= '0;
			out_kind_q   <= kind;
			out_type_q   <= type_q;
			out_ck_q     <= 1'b0;
			out_fwd_q    <= 1'b0;
			out_ovs_q    <= 1'b0;
			out_status_q <= reply_q;
			out_last_q   <= 1'b1;
		end else if (cmd.load_byte) begin
			out_byte_q   <= load_val;
			out_kind_q   <= kind_q;
			out_type_q   <= type_q;
			out_ck_q     <= ck_q;
			out_fwd_q    <= 1'b1;
			out_ovs_q    <= 1'b0;
			out_status_q <= reply_q;
			out_last_q   <= idx_q == end_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_ovs_q, out_status_q, out_fwd_q, out_ck_q, out_type_q, out_byte_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- rtl/swfd_ctrl.sv -----
// Controller: sequences byte intake, header and frame evaluation and result readout.
// Depends on swfd_pkg.
module swfd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_command,
	output logic                  in_ready,
	input  swfd_pkg::dp_status_t  status,
	output swfd_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_HOLD  = 3'd4;

	logic [2:0] state_q, state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_command) begin
						cmd.arm = 1'b1;
					end else begin
						cmd.store = 1'b1;
						state_d   = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
				if (status.hdr_full) begin
					if (!status.hdr_ok) begin
						cmd.drop = 1'b1;
					end else if (status.oversize) begin
						cmd.clear    = 1'b1;
						cmd.load_ovs = 1'b1;
						state_d      = ST_HOLD;
					end
				end else if (status.frame_done) begin
					cmd.clear = 1'b1;
					if (status.is_data && !status.ck_ok) begin
						cmd.load_bad = 1'b1;
						state_d      = ST_HOLD;
					end else begin
						cmd.start_emit = 1'b1;
						cmd.settle     = !status.is_data;
						state_d        = ST_FETCH;
					end
				end
			end
			ST_FETCH: state_d = ST_LOAD;
			ST_LOAD: begin
				cmd.load_byte = 1'b1;
				state_d       = ST_HOLD;
			end
			ST_HOLD: begin
				if (status.out_taken) begin
					if (status.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_FETCH;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/sync_word_frame_deframer_unit.sv -----
// Top level of the sync word frame deframer: controller plus datapath.
// Depends on swfd_pkg, swfd_ctrl, swfd_dp and swfd_ram.
//
// Bytes arrive one per transfer on the s_ side (s_tuser = 1 arms the awaited reply
// code instead). A byte is stored, then evaluated; one that completes a frame is followed
// by a readout through fetch, load and hold per result byte, the fetch waiting out the
// frame store's registered read. The input is held off during readout. Oversize,
// bad checksum and runt frames are reported or dropped as described per field.
// The store needs no clearing after reset. Configuration writes are always taken
// and must only be issued while the block is idle.
module sync_word_frame_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // rx_byte[7:0], awaited_code[23:8]
	input  logic [0:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // frame_byte, frame_type, checksum_ok, forwarded,
	                               // reply_status[1:0], oversize_error, zero pad
	output logic [1:0]  m_tuser,   // frame_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	swfd_pkg::ctrl_cmd_t  cmd;
	swfd_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	swfd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser[0]),
		.in_ready   (s_tready),
		.status     (status),
		.cmd        (cmd)
	);

	swfd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.rx_byte      (s_tdata[7:0]),
		.awaited_code (s_tdata[23:8]),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule

// ----- rtl/swfd_checker.sv -----
// Port-level assertions for the sync word frame deframer, bound to the top level.
// Depends on swfd_pkg.
module swfd_assert (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_ready
);

	// input is only taken when no result is outstanding
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input ready while result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_ovs_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[swfd_pkg::OUT_OVS_BIT] |-> m_tlast && !m_tdata[swfd_pkg::OUT_FWD_BIT])
		else $error("oversize report not a lone result");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[swfd_pkg::OUT_FWD_BIT] |-> m_tlast)
		else $error("rejected frame gave more than one result");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("configuration port stalled");

endmodule

bind sync_word_frame_deframer_unit swfd_assert u_swfd_assert (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);

// ----- test/swfd_checker.sv -----
`timescale 1ns / 100ps
// Deframer checker: watches the byte, result and register channels, predicts results.
// Depends on swfd_pkg; instantiated beside the unit by tb.
module swfd_checker import swfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0]  fbyte;
		logic [1:0]  kind;
		logic [15:0] ftype;
		logic        ck;
		logic        fwd;
		logic [1:0]  status;
		logic        ovs;
		logic        last;
	} frame_res_t;

	frame_res_t  res_q[$];
	logic [7:0]  store_mem[MAX_FRAME];
	int          fill;
	logic [7:0]  run_xor;
	logic [15:0] await_code;
	logic [1:0]  reply_st;
	logic [15:0] kind_type[3];
	logic [5:0]  kind_len[3];

	function automatic void emit(logic [7:0] b, logic [1:0] k, logic [15:0] t,
			logic ck, logic fwd, logic ovs);
		frame_res_t r;
		r = '{b, k, t, ck, fwd, reply_st, ovs, 1'b0};
		res_q.push_back(r);
	endfunction

	function automatic void settle(logic [15:0] t, int len);
		logic [7:0] r;
		if (reply_st != RS_PENDING || t != await_code)
			return;
		if (t == SPECIAL_REPLY) begin
			if (store_mem[8] == MARK_STATUS) begin
				r = (len > 15) ? store_mem[15] : 8'd0;
				reply_st = (r == RES_SUCCESS) ? RS_SUCCESS :
				           (r == RES_FAILED) ? RS_FAILED : RS_UNKNOWN;
			end else if (store_mem[8] == MARK_FAILED) begin
				reply_st = RS_FAILED;
			end else begin
				reply_st = RS_SUCCESS;
			end
		end else begin
			reply_st = RS_SUCCESS;
		end
	endfunction

	// one received byte: header search, oversize drop, frame completion
	function automatic void take_byte(logic [7:0] b);
		int plen, total, len, start_n;
		logic [15:0] t;
		logic [1:0] k;
		logic ck;
		start_n = res_q.size();
		if (fill >= MAX_FRAME) begin
			fill = 0;
			run_xor = 0;
		end
		store_mem[fill] = b;
		fill++;
		run_xor ^= b;
		total = {store_mem[1], store_mem[0]};
		plen = {store_mem[5], store_mem[4]};
		if (fill == HDR_BYTES) begin
			if (!(store_mem[2] == SYNC_FIRST && store_mem[3] == SYNC_SECOND &&
					total == plen + 4 && plen >= 3)) begin
				run_xor ^= store_mem[0];
				for (int i = 0; i < HDR_BYTES - 1; i++)
					store_mem[i] = store_mem[i + 1];
				fill = HDR_BYTES - 1;
			end else if (plen + 6 > MAX_FRAME) begin
				fill = 0;
				run_xor = 0;
				emit(8'd0, 2'd0, 16'd0, 1'b0, 1'b0, 1'b1);
			end
		end else if (fill > HDR_BYTES && fill == plen + 6) begin
			len = plen + 6;
			t = {store_mem[7], store_mem[6]};
			ck = (run_xor == 8'd0);
			k = KIND_REPLY;
			for (int i = 2; i >= 0; i--)
				if (t == kind_type[i] && plen == kind_len[i])
					k = 2'(i);
			if (k != KIND_REPLY) begin
				if (ck)
					for (int i = 0; i < len; i++)
						emit(store_mem[i], k, t, 1'b1, 1'b1, 1'b0);
				else
					emit(8'd0, k, t, 1'b0, 1'b0, 1'b0);
			end else begin
				settle(t, len);
				for (int i = 4; i < len; i++)
					emit(store_mem[i], KIND_REPLY, t, ck, 1'b1, 1'b0);
			end
			fill = 0;
			run_xor = 0;
		end
		if (res_q.size() > start_n)
			res_q[res_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_res_t e, got;
		if (!arst_n) begin
			res_q.delete();
			fill = 0;
			run_xor = 0;
			await_code = 0;
			reply_st = RS_PENDING;
			kind_type = '{16'd618, 16'd3841, 16'd620};
			kind_len = '{6'd26, 6'd16, 6'd17};
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMU_TYPE:    kind_type[0] = cfg_data;
					REG_IMU_LEN:     kind_len[0] = cfg_data[5:0];
					REG_VSYNC_TYPE:  kind_type[1] = cfg_data;
					REG_VSYNC_LEN:   kind_len[1] = cfg_data[5:0];
					REG_HANDLE_TYPE: kind_type[2] = cfg_data;
					REG_HANDLE_LEN:  kind_len[2] = cfg_data[5:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[7:0], m_tuser, m_tdata[23:8], m_tdata[OUT_CK_BIT],
				        m_tdata[OUT_FWD_BIT], m_tdata[27:26], m_tdata[OUT_OVS_BIT], m_tlast};
				if (res_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					errors <= errors + 1;
				end else begin
					e = res_q.pop_front();
					if (got !== e || m_tdata[31:29] !== 3'd0) begin
						$display("%0t: result mismatch, expected %h, actual %h (pad %b)",
						         $time, e, got, m_tdata[31:29]);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) begin
					await_code = s_tdata[23:8];
					reply_st = RS_PENDING;
				end else begin
					take_byte(s_tdata[7:0]);
				end
			end
			pending <= res_q.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte and register stimulus, verdict.
// Depends on swfd_pkg, sync_word_frame_deframer_unit and swfd_checker.
module tb;
	import swfd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          errors, pending;
	int          burst_left = 0;
	int          byte_count = 0;
	int          cyc = 0;
	logic [15:0] kind_type[3] = '{16'd618, 16'd3841, 16'd620};
	logic [5:0]  kind_len[3] = '{6'd26, 6'd16, 6'd17};
	logic [15:0] armed = 16'd0;

	sync_word_frame_deframer_unit u_top (.*);

	swfd_checker u_chk (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sink stall pattern rotates through always ready, random and a fixed duty pattern
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case ((cyc / 300) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= $urandom_range(0, 1);
			default: m_tready <= (cyc % 7) < 3;
		endcase
	end

	task automatic send(input logic cmd, input logic [7:0] b, input logic [15:0] code);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {code, b};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (!cmd)
			byte_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send(1'b0, b, 16'($urandom));
	endtask

	task automatic arm(input logic [15:0] code);
		send(1'b1, 8'($urandom), code);
		armed = code;
	endtask

	// whole frame; optional status mark at byte 8 and result at byte 15,
	// bad checksum, or one corrupted header byte
	task automatic send_frame(input int plen, input logic [15:0] ft, input bit bad_ck,
			input bit marked, input logic [7:0] mark, input logic [7:0] res,
			input bit broken = 0);
		logic [7:0] fb[MAX_FRAME];
		logic [7:0] x;
		int len;
		len = plen + 6;
		x = 0;
		fb[0] = 8'(plen + 4);
		fb[1] = 8'((plen + 4) >> 8);
		fb[2] = SYNC_FIRST;
		fb[3] = SYNC_SECOND;
		fb[4] = 8'(plen);
		fb[5] = 8'(plen >> 8);
		fb[6] = ft[7:0];
		fb[7] = ft[15:8];
		for (int i = 8; i < len - 1; i++)
			fb[i] = 8'($urandom);
		if (marked) begin
			fb[8] = mark;
			if (len > 16)
				fb[15] = res;
		end
		for (int i = 0; i < len - 1; i++)
			x ^= fb[i];
		fb[len - 1] = bad_ck ? ~x : x;
		if (broken)
			fb[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
		for (int i = 0; i < len; i++)
			send_byte(fb[i]);
	endtask

	task automatic settle_out;
		if (burst_left != 0 || s_tvalid) begin
			s_tvalid <= 1'b0;
			burst_left = 0;
		end
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_IMU_TYPE:    kind_type[0] = val;
			REG_IMU_LEN:     kind_len[0] = val[5:0];
			REG_VSYNC_TYPE:  kind_type[1] = val;
			REG_VSYNC_LEN:   kind_len[1] = val[5:0];
			REG_HANDLE_TYPE: kind_type[2] = val;
			REG_HANDLE_LEN:  kind_len[2] = val[5:0];
			default: ;
		endcase
	endtask

	task automatic random_traffic(input int count);
		int r, k, target;
		logic [7:0] mk, rs;
		target = byte_count + count;
		while (byte_count < target) begin
			r = $urandom_range(0, 9);
			k = $urandom_range(0, 2);
			mk = ($urandom_range(0, 2) == 0) ? MARK_STATUS :
			     ($urandom_range(0, 1) == 0) ? MARK_FAILED : 8'($urandom);
			rs = ($urandom_range(0, 2) == 0) ? RES_SUCCESS :
			     ($urandom_range(0, 1) == 0) ? RES_FAILED : 8'($urandom);
			if (r <= 4 && kind_len[k] >= 3)
				send_frame(kind_len[k], kind_type[k], $urandom_range(0, 4) == 0, 0, 0, 0);
			else if (r <= 6)
				send_frame($urandom_range(3, 10),
				           ($urandom_range(0, 1) != 0) ? armed : 16'($urandom), 0, 1, mk, rs);
			else if (r == 7)
				arm(($urandom_range(0, 2) == 0) ? SPECIAL_REPLY : 16'($urandom));
			else if (r == 8)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			else
				send_frame($urandom_range(3, 6), 16'($urandom), 0, 0, 0, 0, 1);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: good and bad data frames, replies and their status cases
		send_frame(16, 16'd3841, 0, 0, 0, 0);
		send_frame(17, 16'd620, 1, 0, 0, 0);
		send_frame(3, 16'd0, 1, 0, 0, 0);          // reply of type 0, the awaited code left by reset
		arm(SPECIAL_REPLY);
		send_frame(11, SPECIAL_REPLY, 0, 1, MARK_STATUS, RES_FAILED);
		arm(SPECIAL_REPLY);
		send_frame(4, SPECIAL_REPLY, 0, 1, MARK_STATUS, 8'h00);   // short reply
		arm(SPECIAL_REPLY);
		send_frame(3, SPECIAL_REPLY, 0, 1, MARK_FAILED, 8'h00);
		// oversize header, then its would-be payload as loose bytes
		send_byte(8'd63); send_byte(8'd0); send_byte(SYNC_FIRST); send_byte(SYNC_SECOND);
		send_byte(8'd59); send_byte(8'd0);
		send_byte(8'h00); send_byte(8'hFF);
		// runt header: payload length 2
		send_byte(8'd6); send_byte(8'd0); send_byte(SYNC_FIRST); send_byte(SYNC_SECOND);
		send_byte(8'd2); send_byte(8'd0);
		settle_out();

		// extremes of the registers
		write_reg(REG_IMU_TYPE, 16'h0000);
		write_reg(REG_IMU_LEN, 16'd0);
		write_reg(REG_VSYNC_TYPE, 16'hFFFF);
		write_reg(REG_VSYNC_LEN, 16'd3);
		write_reg(REG_HANDLE_TYPE, SPECIAL_REPLY);
		write_reg(REG_HANDLE_LEN, 16'd3);
		send_frame(3, SPECIAL_REPLY, 0, 0, 0, 0);
		random_traffic(15);
		settle_out();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
